// ===== rtl/core/rigid_vertex_skinning_transform_assert.svh =====
// Assertion macros shared by the skinning transform RTL.
// Needs signals named clk and arst_n in the scope of use.
`ifndef RIGID_VERTEX_SKINNING_TRANSFORM_ASSERT_SVH
`define RIGID_VERTEX_SKINNING_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define RVST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvst: assertion failed");

// next-cycle implication
`define RVST_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvst: assertion failed");

`endif

// ===== rtl/core/rvst_pkg.sv =====
// Shared types and constants for the rigid skinning transform.
// No dependencies.
package rvst_pkg;

	localparam int RVST_BONE_COUNT = 64;
	localparam int RVST_COEFS      = 12;
	localparam int RVST_QDEPTH     = 4;

	// operation codes
	localparam logic RVST_OP_LOAD = 1'b0;

	// vertex as it leaves the front end
	typedef struct packed {
		logic        apply;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
	} rvst_vtx_t;

	// queue entry: vertex plus the bone's twelve coefficients
	typedef struct packed {
		rvst_vtx_t                   vtx;
		logic [RVST_COEFS-1:0][31:0] coef;
	} rvst_qent_t;

endpackage

// ===== rtl/core/rvst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/rvst_front.sv =====
// Front end: accepts requests, writes coefficients, fetches a bone's matrix.
// Depends on rvst_pkg and rvst_ram.
module rvst_front import rvst_pkg::*; #(
	parameter int BONE_COUNT = RVST_BONE_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic               has_bone,
	input  logic [5:0]         bone_index,
	input  logic [3:0]         coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic               q_full,
	output logic               q_push,
	output rvst_qent_t         q_data
);

	localparam int AW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

	logic                        accept;
	logic                        is_load;
	logic                        in_range;
	logic [8:0]                  bone_ext;
	logic [AW-1:0]               addr;
	logic [RVST_COEFS-1:0][31:0] coef_rd;
	logic                        valid_s1;
	rvst_vtx_t                   vtx_s1;

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign is_load  = (operation == RVST_OP_LOAD);
	assign bone_ext = {3'b000, bone_index};
	assign in_range = bone_ext < 9'(BONE_COUNT);
	assign addr     = bone_ext[AW-1:0];

	// one RAM per coefficient, so a vertex fetches its whole matrix at once
	for (genvar k = 0; k < RVST_COEFS; k++) begin : g_coef
		rvst_ram #(
			.WIDTH(32),
			.DEPTH(BONE_COUNT)
		) u_ram (
			.clk   (clk),
			.we    (accept && is_load && in_range && (coef_index == 4'(k))),
			.waddr (addr),
			.wdata (coef_value),
			.re    (accept && !is_load),
			.raddr (addr),
			.rdata (coef_rd[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || !q_full) begin
			valid_s1 <= accept && !is_load;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_load) begin
			vtx_s1.apply <= has_bone && in_range;
			vtx_s1.px    <= pos_x;
			vtx_s1.py    <= pos_y;
			vtx_s1.pz    <= pos_z;
			vtx_s1.nx    <= norm_x;
			vtx_s1.ny    <= norm_y;
			vtx_s1.nz    <= norm_z;
		end
	end

	assign q_push      = valid_s1 && !q_full;
	assign q_data.vtx  = vtx_s1;
	assign q_data.coef = coef_rd;

endmodule

// ===== rtl/core/rvst_queue.sv =====
// Short queue between front end and arithmetic back end.
// Depends on rvst_pkg and the assertion macro header.
`include "rigid_vertex_skinning_transform_assert.svh"
module rvst_queue import rvst_pkg::*; #(
	parameter int DEPTH = RVST_QDEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rvst_qent_t wdata,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output rvst_qent_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rvst_qent_t     ent_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

	`RVST_ASSERT_IMP(a_no_push_full, push, cnt_q != CW'(DEPTH))
	`RVST_ASSERT_IMP(a_no_pop_empty, pop, cnt_q != '0)
	`RVST_ASSERT_NXT(a_cnt_grows, push && !pop, cnt_q == $past(cnt_q) + CW'(1))

endmodule

// ===== rtl/core/rvst_back.sv =====
// Back end: matrix multiply, saturation, normal renormalization pipeline.
// Depends on rvst_pkg.
module rvst_back import rvst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  rvst_qent_t         head,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [15:0] out_norm_x,
	output logic signed [15:0] out_norm_y,
	output logic signed [15:0] out_norm_z,
	output logic               zero_normal
);

	localparam int RT_STEPS = 31;
	localparam int DV_STEPS = 15;
	localparam int LAT      = 8 + 1 + RT_STEPS + 1 + DV_STEPS + 1;

	typedef struct packed {
		logic             apply;
		logic             zero;
		logic [2:0]       neg;
		logic [2:0][31:0] pos;
		logic [2:0][15:0] nin;
	} side_t;

	logic           en;
	logic [LAT-1:0] vld_q;

	logic signed [31:0] p_in [3];
	logic signed [15:0] n_in [3];
	logic signed [31:0] c_in [RVST_COEFS];

	side_t              sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7, sd_s8;
	logic signed [63:0] pp_s1 [3][3];
	logic signed [47:0] np_s1 [3][3];
	logic signed [31:0] tr_s1 [3];
	logic signed [65:0] psum_s2 [3];
	logic signed [49:0] ns_s2 [3];
	logic [31:0]        pos_n [3];
	logic [49:0]        hi_n [3];
	logic signed [49:0] abs_n [3];
	logic [47:0]        mg_s3 [3];
	logic [47:0]        mg_s4 [3];
	logic [47:0]        m_s4;
	logic [47:0]        m01_n;
	logic [47:0]        mg_s5 [3];
	logic [5:0]         nz_s5;
	logic [2:0]         lp_n [6];
	logic [2:0]         lp_s5 [6];
	logic [47:0]        mg_s6 [3];
	logic [5:0]         p_n;
	logic [5:0]         p_s6;
	logic [5:0]         sh_r;
	logic [5:0]         sh_l;
	logic [47:0]        shf_n [3];
	logic [29:0]        sm_s7 [3];
	logic [29:0]        sm_s8 [3];
	logic [59:0]        sqr_s8 [3];

	logic [61:0]      rt_rem_q  [RT_STEPS+1];
	logic [30:0]      rt_root_q [RT_STEPS+1];
	side_t            sd_rt_q   [RT_STEPS+1];
	logic [2:0][29:0] mg_rt_q   [RT_STEPS+1];
	logic [62:0]      rt_try  [RT_STEPS];
	logic [61:0]      rt_rem_n  [RT_STEPS];
	logic [30:0]      rt_root_n [RT_STEPS];

	logic [30:0]      dv_len_q [DV_STEPS+1];
	logic [2:0][45:0] dv_rem_q [DV_STEPS+1];
	logic [2:0][14:0] dv_q     [DV_STEPS+1];
	side_t            sd_dv_q  [DV_STEPS+1];
	logic [45:0]      dv_div [DV_STEPS];
	logic [2:0][45:0] dv_rem_n [DV_STEPS];
	logic [2:0][14:0] dv_q_n   [DV_STEPS];

	logic [15:0] qs_n [3];
	logic [15:0] on_n [3];
	logic [31:0] opos_q [3];
	logic [15:0] onrm_q [3];
	logic        zero_q;

	// stall everything while the result register is held
	assign en        = !(vld_q[LAT-1] && out_stall);
	assign q_pop     = en && !q_empty;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], q_pop};
		end
	end

	always_comb begin
		p_in[0] = $signed(head.vtx.px);
		p_in[1] = $signed(head.vtx.py);
		p_in[2] = $signed(head.vtx.pz);
		n_in[0] = $signed(head.vtx.nx);
		n_in[1] = $signed(head.vtx.ny);
		n_in[2] = $signed(head.vtx.nz);
		for (int k = 0; k < RVST_COEFS; k++) begin
			c_in[k] = $signed(head.coef[k]);
		end
	end

	// saturate position, take normal magnitudes
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			hi_n[c] = psum_s2[c][65:16];
			if (hi_n[c][49:31] == {19{hi_n[c][31]}}) begin
				pos_n[c] = hi_n[c][31:0];
			end else if (hi_n[c][49]) begin
				pos_n[c] = 32'h8000_0000;
			end else begin
				pos_n[c] = 32'h7fff_ffff;
			end
			abs_n[c] = ns_s2[c][49] ? -ns_s2[c] : ns_s2[c];
		end
	end

	// largest magnitude and leading-one search, per byte lane and then across lanes
	always_comb begin
		m01_n = (mg_s3[0] > mg_s3[1]) ? mg_s3[0] : mg_s3[1];
		for (int b = 0; b < 6; b++) begin
			lp_n[b] = '0;
			for (int i = 0; i < 8; i++) begin
				if (m_s4[b*8 + i]) begin
					lp_n[b] = 3'(i);
				end
			end
		end
		p_n = '0;
		for (int b = 0; b < 6; b++) begin
			if (nz_s5[b]) begin
				p_n = 6'(b * 8) + {3'b000, lp_s5[b]};
			end
		end
		sh_r = p_s6 - 6'd29;
		sh_l = 6'd29 - p_s6;
		for (int l = 0; l < 3; l++) begin
			shf_n[l] = (p_s6 >= 6'd29) ? (mg_s6[l] >> sh_r) : (mg_s6[l] << sh_l);
		end
	end

	// square root, one result bit a stage
	always_comb begin
		for (int j = 0; j < RT_STEPS; j++) begin
			rt_try[j] = (63'(rt_root_q[j]) << (RT_STEPS - j))
				+ (63'd1 << (2 * (RT_STEPS - 1 - j)));
			if ({1'b0, rt_rem_q[j]} >= rt_try[j]) begin
				rt_rem_n[j]  = rt_rem_q[j] - rt_try[j][61:0];
				rt_root_n[j] = rt_root_q[j] | (31'd1 << (RT_STEPS - 1 - j));
			end else begin
				rt_rem_n[j]  = rt_rem_q[j];
				rt_root_n[j] = rt_root_q[j];
			end
		end
	end

	// restoring divide, one quotient bit a stage
	always_comb begin
		for (int j = 0; j < DV_STEPS; j++) begin
			dv_div[j] = 46'(dv_len_q[j]) << (DV_STEPS - 1 - j);
			for (int l = 0; l < 3; l++) begin
				if (dv_rem_q[j][l] >= dv_div[j]) begin
					dv_rem_n[j][l] = dv_rem_q[j][l] - dv_div[j];
					dv_q_n[j][l]   = dv_q[j][l] | (15'd1 << (DV_STEPS - 1 - j));
				end else begin
					dv_rem_n[j][l] = dv_rem_q[j][l];
					dv_q_n[j][l]   = dv_q[j][l];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qs_n[l] = {1'b0, dv_q[DV_STEPS][l]};
			if (!sd_dv_q[DV_STEPS].apply) begin
				on_n[l] = sd_dv_q[DV_STEPS].nin[l];
			end else if (sd_dv_q[DV_STEPS].zero) begin
				on_n[l] = '0;
			end else if (sd_dv_q[DV_STEPS].neg[l]) begin
				on_n[l] = ~qs_n[l] + 16'd1;
			end else begin
				on_n[l] = qs_n[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// products
			sd_s1.apply  <= head.vtx.apply;
			sd_s1.zero   <= 1'b0;
			sd_s1.neg    <= '0;
			sd_s1.pos[0] <= head.vtx.px;
			sd_s1.pos[1] <= head.vtx.py;
			sd_s1.pos[2] <= head.vtx.pz;
			sd_s1.nin[0] <= head.vtx.nx;
			sd_s1.nin[1] <= head.vtx.ny;
			sd_s1.nin[2] <= head.vtx.nz;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pp_s1[r][c] <= p_in[r] * c_in[r*3 + c];
					np_s1[r][c] <= n_in[r] * c_in[r*3 + c];
				end
				tr_s1[r] <= c_in[9 + r];
			end
			// sums, rounding half added up front
			sd_s2 <= sd_s1;
			for (int c = 0; c < 3; c++) begin
				psum_s2[c] <= (66'(tr_s1[c]) <<< 16) + 66'(pp_s1[0][c])
					+ 66'(pp_s1[1][c]) + 66'(pp_s1[2][c]) + 66'sd32768;
				ns_s2[c] <= 50'(np_s1[0][c]) + 50'(np_s1[1][c]) + 50'(np_s1[2][c]);
			end
			// saturate, split sign and magnitude
			sd_s3.apply <= sd_s2.apply;
			sd_s3.zero  <= sd_s2.zero;
			sd_s3.nin   <= sd_s2.nin;
			for (int c = 0; c < 3; c++) begin
				sd_s3.pos[c] <= sd_s2.apply ? pos_n[c] : sd_s2.pos[c];
				sd_s3.neg[c] <= ns_s2[c][49];
				mg_s3[c]     <= abs_n[c][47:0];
			end
			// maximum
			sd_s4 <= sd_s3;
			mg_s4 <= mg_s3;
			m_s4  <= (m01_n > mg_s3[2]) ? m01_n : mg_s3[2];
			// per-byte leading one
			sd_s5 <= sd_s4;
			mg_s5 <= mg_s4;
			for (int b = 0; b < 6; b++) begin
				nz_s5[b] <= |m_s4[b*8 +: 8];
			end
			lp_s5 <= lp_n;
			// leading-one position
			sd_s6.apply <= sd_s5.apply;
			sd_s6.zero  <= ~|nz_s5;
			sd_s6.neg   <= sd_s5.neg;
			sd_s6.pos   <= sd_s5.pos;
			sd_s6.nin   <= sd_s5.nin;
			mg_s6       <= mg_s5;
			p_s6        <= p_n;
			// scale so the largest lies in [2^29, 2^30)
			sd_s7 <= sd_s6;
			for (int l = 0; l < 3; l++) begin
				sm_s7[l] <= shf_n[l][29:0];
			end
			// squares
			sd_s8 <= sd_s7;
			sm_s8 <= sm_s7;
			for (int l = 0; l < 3; l++) begin
				sqr_s8[l] <= 60'(sm_s7[l]) * 60'(sm_s7[l]);
			end
			// sum of squares enters the root pipe
			rt_rem_q[0]  <= 62'(sqr_s8[0]) + 62'(sqr_s8[1]) + 62'(sqr_s8[2]);
			rt_root_q[0] <= '0;
			sd_rt_q[0]   <= sd_s8;
			for (int l = 0; l < 3; l++) begin
				mg_rt_q[0][l] <= sm_s8[l];
			end
			for (int j = 0; j < RT_STEPS; j++) begin
				rt_rem_q[j+1]  <= rt_rem_n[j];
				rt_root_q[j+1] <= rt_root_n[j];
				sd_rt_q[j+1]   <= sd_rt_q[j];
				mg_rt_q[j+1]   <= mg_rt_q[j];
			end
			// dividend with half the divisor for rounding
			dv_len_q[0] <= rt_root_q[RT_STEPS];
			sd_dv_q[0]  <= sd_rt_q[RT_STEPS];
			for (int l = 0; l < 3; l++) begin
				dv_rem_q[0][l] <= (46'(mg_rt_q[RT_STEPS][l]) << 14)
					+ 46'(rt_root_q[RT_STEPS] >> 1);
				dv_q[0][l]     <= '0;
			end
			for (int j = 0; j < DV_STEPS; j++) begin
				dv_len_q[j+1] <= dv_len_q[j];
				dv_rem_q[j+1] <= dv_rem_n[j];
				dv_q[j+1]     <= dv_q_n[j];
				sd_dv_q[j+1]  <= sd_dv_q[j];
			end
			// result register
			for (int l = 0; l < 3; l++) begin
				opos_q[l] <= sd_dv_q[DV_STEPS].pos[l];
				onrm_q[l] <= on_n[l];
			end
			zero_q <= sd_dv_q[DV_STEPS].apply && sd_dv_q[DV_STEPS].zero;
		end
	end

	assign out_pos_x   = $signed(opos_q[0]);
	assign out_pos_y   = $signed(opos_q[1]);
	assign out_pos_z   = $signed(opos_q[2]);
	assign out_norm_x  = $signed(onrm_q[0]);
	assign out_norm_y  = $signed(onrm_q[1]);
	assign out_norm_z  = $signed(onrm_q[2]);
	assign zero_normal = zero_q;

endmodule

// ===== rtl/core/rigid_vertex_skinning_transform.sv =====
// Top level of the rigid single-bone skinning transform.
// Depends on rvst_pkg, rvst_front, rvst_queue and rvst_back.
//
//   channel | handshake          | carries
//   --------+--------------------+-------------------------------------------
//   input   | in_valid/in_stall  | coefficient load or vertex request
//   output  | out_valid/out_stall| transformed vertex, one per vertex request
//
// Throughput is one request per cycle while in_stall is low; loads and vertices mix freely.
// A vertex passes through the matrix fetch from the per-coefficient RAMs, the
// queue and the arithmetic pipe, whose depth is set by the 31-step square
// root and the 15-step divide.
// Reset clears valid bits and queue pointers only; coefficient RAMs are
// undefined until written.
// An output stall with out_valid high freezes the arithmetic pipe; the queue
// keeps taking requests until full, then in_stall rises.
module rigid_vertex_skinning_transform import rvst_pkg::*; #(
	parameter int BONE_COUNT  = RVST_BONE_COUNT,
	parameter int QUEUE_DEPTH = RVST_QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic               has_bone,
	input  logic [5:0]         bone_index,
	input  logic [3:0]         coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [15:0] out_norm_x,
	output logic signed [15:0] out_norm_y,
	output logic signed [15:0] out_norm_z,
	output logic               zero_normal
);

	// front end to queue
	logic       q_full;
	logic       q_push;
	rvst_qent_t q_wdata;
	// queue to back end
	logic       q_empty;
	logic       q_pop;
	rvst_qent_t q_head;

	// accept requests, store coefficients, fetch the bone matrix
	rvst_front #(
		.BONE_COUNT(BONE_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.has_bone   (has_bone),
		.bone_index (bone_index),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.norm_x     (norm_x),
		.norm_y     (norm_y),
		.norm_z     (norm_z),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	// decouple the front end from output stalls
	rvst_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_head)
	);

	// transform, saturate, renormalize
	rvst_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.head        (q_head),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_pos_x   (out_pos_x),
		.out_pos_y   (out_pos_y),
		.out_pos_z   (out_pos_z),
		.out_norm_x  (out_norm_x),
		.out_norm_y  (out_norm_y),
		.out_norm_z  (out_norm_z),
		.zero_normal (zero_normal)
	);

endmodule

// ===== test/rvst_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the rigid skinning transform: watches both channels,
// predicts each vertex result from its own bone store and compares.
// Depends on rvst_pkg for the operation code.
module rvst_checker import rvst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               operation,
	input  logic               has_bone,
	input  logic [5:0]         bone_index,
	input  logic [3:0]         coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] out_pos_x,
	input  logic signed [31:0] out_pos_y,
	input  logic signed [31:0] out_pos_z,
	input  logic signed [15:0] out_norm_x,
	input  logic signed [15:0] out_norm_y,
	input  logic signed [15:0] out_norm_z,
	input  logic               zero_normal,
	output int                 fail_count,
	output int                 pending,
	output int                 vertex_count,
	output int                 load_count
);

	typedef struct packed {
		logic signed [31:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic               zn;
	} skinned_vtx_t;

	logic signed [31:0] bone_coef [RVST_BONE_COUNT][RVST_COEFS];
	skinned_vtx_t       skinned_q [$];

	initial begin
		fail_count = 0;
		vertex_count = 0;
		load_count = 0;
	end

	assign pending = skinned_q.size();

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic skinned_vtx_t skin_vertex(input logic apply, input logic [5:0] bi,
			input longint p [3], input longint n [3]);
		skinned_vtx_t        v;
		logic signed [127:0] acc;
		longint              s;
		logic [63:0]         mag [3];
		logic [63:0]         m, sq, len, q;
		logic                neg [3];
		int                  rs, ls;
		v.px = 32'(p[0]); v.py = 32'(p[1]); v.pz = 32'(p[2]);
		v.nx = 16'(n[0]); v.ny = 16'(n[1]); v.nz = 16'(n[2]);
		v.zn = 1'b0;
		if (!apply || bi >= RVST_BONE_COUNT)
			return v;
		m = 0;
		for (int c = 0; c < 3; c++) begin
			// exact sum with translation at full precision, round half up, saturate
			acc = 128'(bone_coef[bi][9 + c]) <<< 16;
			s = 0;
			for (int r = 0; r < 3; r++) begin
				acc += 128'(p[r]) * 128'(bone_coef[bi][r * 3 + c]);
				s += n[r] * longint'(bone_coef[bi][r * 3 + c]);
			end
			acc = (acc + 128'sd32768) >>> 16;
			if (acc > 128'sd2147483647)
				acc = 128'sd2147483647;
			if (acc < -128'sd2147483648)
				acc = -128'sd2147483648;
			case (c)
				0: v.px = acc[31:0];
				1: v.py = acc[31:0];
				default: v.pz = acc[31:0];
			endcase
			neg[c] = s < 0;
			mag[c] = neg[c] ? -s : s;
			if (mag[c] > m)
				m = mag[c];
		end
		if (m == 0) begin
			v.nx = 0; v.ny = 0; v.nz = 0;
			v.zn = 1'b1;
			return v;
		end
		// bring the largest magnitude into [2^29, 2^30)
		rs = 0;
		ls = 0;
		while ((m >> rs) >= (64'h1 << 30))
			rs++;
		while ((m << ls) < (64'h1 << 29))
			ls++;
		sq = 0;
		for (int c = 0; c < 3; c++) begin
			mag[c] = (mag[c] >> rs) << ls;
			sq += mag[c] * mag[c];
		end
		len = int_sqrt(sq);
		for (int c = 0; c < 3; c++) begin
			q = ((mag[c] << 14) + (len >> 1)) / len;
			if (neg[c])
				q = -q;
			case (c)
				0: v.nx = q[15:0];
				1: v.ny = q[15:0];
				default: v.nz = q[15:0];
			endcase
		end
		return v;
	endfunction

	// input side: update the store on loads, queue a prediction per vertex
	always @(posedge clk) begin
		longint p [3], n [3];
		if (arst_n && in_valid && !in_stall) begin
			if (operation == RVST_OP_LOAD) begin
				load_count++;
				if (coef_index < RVST_COEFS)
					bone_coef[bone_index][coef_index] <= coef_value;
			end else begin
				p[0] = longint'(pos_x); p[1] = longint'(pos_y); p[2] = longint'(pos_z);
				n[0] = longint'(norm_x); n[1] = longint'(norm_y); n[2] = longint'(norm_z);
				skinned_q = {skinned_q, skin_vertex(has_bone, bone_index, p, n)};
			end
		end
	end

	// output side: compare each result against the oldest prediction
	always @(posedge clk) begin
		skinned_vtx_t exp_v, got_v;
		if (arst_n && out_valid && !out_stall) begin
			got_v = {out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
				zero_normal};
			vertex_count++;
			if (skinned_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result %h", $time, got_v);
			end else begin
				exp_v = skinned_q.pop_front();
				if (got_v !== exp_v) begin
					fail_count++;
					$display("%0t: mismatch expected pos %0d %0d %0d norm %0d %0d %0d zn %b",
						$time, exp_v.px, exp_v.py, exp_v.pz, exp_v.nx, exp_v.ny, exp_v.nz,
						exp_v.zn);
					$display("%0t:            actual pos %0d %0d %0d norm %0d %0d %0d zn %b",
						$time, got_v.px, got_v.py, got_v.pz, got_v.nx, got_v.ny, got_v.nz,
						got_v.zn);
				end
			end
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the skinning transform testbench: clock, reset, request stimulus,
// output stall pattern and verdict. Depends on rvst_pkg and rvst_checker.
module tb_top;
	import rvst_pkg::*;

	localparam logic OP_VERTEX  = !RVST_OP_LOAD;
	localparam int   CYCLE_CAP  = 400000;
	localparam int   DRAIN_WAIT = 120;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = RVST_OP_LOAD;
	logic               has_bone = 1'b0;
	logic [5:0]         bone_index = '0;
	logic [3:0]         coef_index = '0;
	logic signed [31:0] coef_value = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [15:0] norm_x = '0, norm_y = '0, norm_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
	logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
	logic               zero_normal;
	int                 fail_count, pending, vertex_count, load_count;
	int                 cycle_count = 0;
	int                 burst_left = 0;

	// per-bone mask of coefficients written so far; a bone is usable once full
	logic [RVST_COEFS-1:0] coef_written [RVST_BONE_COUNT];

	rigid_vertex_skinning_transform dut (.*);

	rvst_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// global watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: stall on a shifting pattern, plus one long hold-off so the
	// queue fills and in_stall rises while requests keep coming
	initial begin
		int mode, hold;
		bit long_done;
		long_done = 0;
		forever begin
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 64; i++) begin
				@(posedge clk);
				if (!long_done && cycle_count > 400) begin
					long_done = 1;
					out_stall <= 1'b1;
					for (hold = 0; hold < 400; hold++)
						@(posedge clk);
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// random 32-bit value with extra weight on the extremes and small numbers
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'sh0;
			3, 4: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [15:0] pick_half();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0;
			default: return 16'($urandom());
		endcase
	endfunction

	// hand one request to the block; idle between bursts, hold until accepted
	task automatic send(input logic op, input logic hb, input logic [5:0] bi,
			input logic [3:0] ci, input logic signed [31:0] cv,
			input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] pz, input logic signed [15:0] nx,
			input logic signed [15:0] ny, input logic signed [15:0] nz);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		has_bone <= hb;
		bone_index <= bi;
		coef_index <= ci;
		coef_value <= cv;
		pos_x <= px; pos_y <= py; pos_z <= pz;
		norm_x <= nx; norm_y <= ny; norm_z <= nz;
		do
			@(posedge clk);
		while (in_stall);
		if (op == RVST_OP_LOAD && ci < RVST_COEFS)
			coef_written[bi][ci] = 1'b1;
	endtask

	task automatic load_coef(input logic [5:0] bi, input logic [3:0] ci,
			input logic signed [31:0] cv);
		send(RVST_OP_LOAD, 1'($urandom()), bi, ci, cv, $urandom(), $urandom(), $urandom(),
			16'($urandom()), 16'($urandom()), 16'($urandom()));
	endtask

	task automatic vertex(input logic hb, input logic [5:0] bi,
			input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] pz, input logic signed [15:0] nx,
			input logic signed [15:0] ny, input logic signed [15:0] nz);
		send(OP_VERTEX, hb, bi, 4'($urandom()), $urandom(), px, py, pz, nx, ny, nz);
	endtask

	// a bone whose coefficients are all written, or -1 if none yet
	function automatic int ready_bone();
		int b;
		b = $urandom_range(0, RVST_BONE_COUNT - 1);
		for (int k = 0; k < RVST_BONE_COUNT; k++)
			if (&coef_written[(b + k) % RVST_BONE_COUNT])
				return (b + k) % RVST_BONE_COUNT;
		return -1;
	endfunction

	initial begin
		int rb, sel;
		for (int b = 0; b < RVST_BONE_COUNT; b++)
			coef_written[b] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bone 0 identity, bone 1 extreme coefficients, bone 63
		// zero rotation for a zero-length normal
		for (int k = 0; k < RVST_COEFS; k++) begin
			load_coef(6'd0, 4'(k), (k == 0 || k == 4 || k == 8) ? Q_ONE : 32'sh0);
			load_coef(6'd1, 4'(k), k[0] ? 32'sh8000_0000 : 32'sh7fff_ffff);
			load_coef(6'd63, 4'(k), (k < 9) ? 32'sh0 : 32'sh7fff_ffff);
		end
		// out-of-range coefficient indexes are dropped
		load_coef(6'd0, 4'd12, 32'sh1234_5678);
		load_coef(6'd0, 4'd15, 32'sh8000_0000);
		vertex(1'b0, 6'd17, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0,
			16'sh7fff, 16'sh8000, 16'sh0);
		vertex(1'b1, 6'd0, 32'sh0012_3456, -32'sh0001_0000, 32'sh7fff_ffff,
			16'sh4000, 16'sh0, 16'sh0);
		vertex(1'b1, 6'd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			16'sh7fff, 16'sh8000, 16'sh7fff);
		vertex(1'b1, 6'd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			16'sh8000, 16'sh8000, 16'sh8000);
		vertex(1'b1, 6'd63, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
			16'sh4000, 16'sh4000, 16'sh4000);
		vertex(1'b1, 6'd0, 32'sh1, 32'sh1, 32'sh1, 16'sh0, 16'sh0, 16'sh0);

		// random: mostly full bone loads followed by vertex streams, with
		// stray single loads and pass-through vertices mixed in
		for (int n = 0; n < 1080; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				rb = $urandom_range(0, RVST_BONE_COUNT - 1);
				for (int k = 0; k < RVST_COEFS; k++)
					load_coef(6'(rb), 4'(k), pick_word());
				n += RVST_COEFS - 1;
			end else if (sel < 25) begin
				load_coef(6'($urandom()), 4'($urandom()), pick_word());
			end else begin
				rb = ready_bone();
				if (rb >= 0 && $urandom_range(0, 4) != 0)
					vertex(1'b1, 6'(rb), pick_word(), pick_word(), pick_word(),
						pick_half(), pick_half(), pick_half());
				else
					vertex(1'b0, 6'($urandom()), pick_word(), pick_word(), pick_word(),
						pick_half(), pick_half(), pick_half());
			end
		end
		in_valid <= 1'b0;

		// drain: wait for every prediction to be matched, then let the pipe settle
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Covered %0d coefficient loads and %0d vertex results, with bursts,",
			load_count, vertex_count);
		$display("random output stalls and one long hold-off that backed up the input.");
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
